// File: sv/dnsrw_pkg.sv
// Shared types and constants for the DNS query to A-reply rewriter.
package dnsrw_pkg;

   // verdict codes carried on the final result
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_SHORT     = 3'd1;
   localparam logic [2:0] ST_OVER_CAP  = 3'd2;
   localparam logic [2:0] ST_RESPONSE  = 3'd3;
   localparam logic [2:0] ST_NO_QUEST  = 3'd4;
   localparam logic [2:0] ST_BAD_LABEL = 3'd5;
   localparam logic [2:0] ST_TRUNC     = 3'd6;
   localparam logic [2:0] ST_NO_ROOM   = 3'd7;

   // configuration register indexes
   localparam logic CSR_REPLY_ADDR = 1'b0;
   localparam logic CSR_BUF_CAP    = 1'b1;

   localparam logic [15:0] BUF_CAP_RESET    = 16'd512;
   localparam logic [15:0] LABEL_POS_RESET  = 16'd12;
   localparam logic [15:0] POS_MAX          = 16'hFFFF;
   localparam logic [7:0]  LABEL_LEN_MAX    = 8'd63;
   localparam logic [7:0]  REPLY_FLAGS_HI   = 8'h81;
   localparam logic [7:0]  REPLY_FLAGS_LO   = 8'h80;
   localparam logic [3:0]  TAIL_LAST_IDX    = 4'd15;
   localparam logic [16:0] HEADER_LEN       = 17'd12;
   // root byte, QTYPE, QCLASS and the answer
   localparam logic [16:0] ROOM_NEEDED      = 17'd21;

   typedef enum logic [4:0] {
      PH_HEADER = 5'b00001,
      PH_LABELS = 5'b00010,
      PH_QTAIL  = 5'b00100,
      PH_DROP   = 5'b01000,
      PH_BAD    = 5'b10000
   } phase_type;

   // one queue entry: a byte to forward and/or the end of a frame
   typedef struct packed {
      logic [7:0] data;
      logic       keep;
      logic       last;
      logic [2:0] status;
   } qent_type;

   // answer record: pointer 0xC00C, type A, class IN, TTL 60, rdlength 4, address
   function automatic logic [7:0] tail_byte(input logic [3:0] idx, input logic [31:0] addr);
      logic [7:0] b;
      case (idx)
         4'd0:    b = 8'hC0;
         4'd1:    b = 8'h0C;
         4'd3:    b = 8'h01;
         4'd5:    b = 8'h01;
         4'd9:    b = 8'h3C;
         4'd11:   b = 8'h04;
         4'd12:   b = addr[31:24];
         4'd13:   b = addr[23:16];
         4'd14:   b = addr[15:8];
         4'd15:   b = addr[7:0];
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

// File: sv/dnsrw_front.sv
// Front end: parses the query header and question and classifies each request.
module dnsrw_front
   import dnsrw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic [15:0] buf_cap,
   input  logic        in_valid,
   output logic        in_ready,
   input  logic [7:0]  in_byte,
   input  logic        in_last,
   output logic        push_valid,
   input  logic        push_ready,
   output qent_type    push_ent
);

   logic [15:0] pos_ff, pos_in;
   logic [15:0] nlp_ff, nlp_in;
   logic [15:0] root_ff, root_in;
   logic [7:0]  qch_ff, qch_in;
   logic [2:0]  err_ff, err_in;
   phase_type   phase_ff, phase_in;

   logic [7:0]  ob;
   logic        keep;
   logic        err_hit;
   logic [2:0]  err_code;
   logic [16:0] nx;
   logic [16:0] len;
   logic [2:0]  st;
   logic        accept;

   always_comb begin
      ob       = in_byte;
      keep     = 1'b1;
      err_hit  = 1'b0;
      err_code = ST_OK;
      phase_in = phase_ff;
      nlp_in   = nlp_ff;
      root_in  = root_ff;
      qch_in   = qch_ff;
      nx       = {1'b0, pos_ff} + 17'(in_byte) + 17'd1;
      case (phase_ff)
         PH_HEADER: begin
            case (pos_ff)
               16'd2: begin
                  if (in_byte[7]) begin
                     err_hit  = 1'b1;
                     err_code = ST_RESPONSE;
                  end
                  ob = REPLY_FLAGS_HI;
               end
               16'd3: ob = REPLY_FLAGS_LO;
               16'd4: qch_in = in_byte;
               16'd5: begin
                  if (qch_ff == 8'd0 && in_byte == 8'd0) begin
                     err_hit  = 1'b1;
                     err_code = ST_NO_QUEST;
                  end
               end
               16'd7: ob = 8'h01;
               16'd6, 16'd8, 16'd9, 16'd10, 16'd11: ob = 8'h00;
               default: ;
            endcase
            if (pos_ff >= 16'd11) phase_in = PH_LABELS;
         end
         PH_LABELS: begin
            if (pos_ff == nlp_ff) begin
               if (in_byte == 8'd0) begin
                  root_in  = pos_ff;
                  phase_in = PH_QTAIL;
               end else if (in_byte > LABEL_LEN_MAX) begin
                  err_hit  = 1'b1;
                  err_code = ST_BAD_LABEL;
                  phase_in = PH_BAD;
               end else begin
                  nlp_in = nx[16] ? POS_MAX : nx[15:0];
               end
            end
         end
         PH_QTAIL: begin
            if ({1'b0, pos_ff} >= {1'b0, root_ff} + 17'd4) phase_in = PH_DROP;
         end
         PH_DROP: keep = 1'b0;
         PH_BAD:  ;
         default: ;
      endcase

      err_in = (err_ff == ST_OK && err_hit) ? err_code : err_ff;
      pos_in = (pos_ff == POS_MAX) ? pos_ff : pos_ff + 16'd1;

      // verdict on the final byte
      len = {1'b0, pos_ff} + 17'd1;
      if (len < HEADER_LEN)                                   st = ST_SHORT;
      else if (len > {1'b0, buf_cap})                         st = ST_OVER_CAP;
      else if (err_in != ST_OK)                               st = err_in;
      else if (phase_in != PH_DROP)                           st = ST_TRUNC;
      else if ({1'b0, root_in} + ROOM_NEEDED > {1'b0, buf_cap}) st = ST_NO_ROOM;
      else                                                    st = ST_OK;
   end

   assign in_ready        = push_ready;
   assign accept          = in_valid && push_ready;
   assign push_valid      = in_valid && (keep || in_last);
   assign push_ent.data   = ob;
   assign push_ent.keep   = keep;
   assign push_ent.last   = in_last;
   assign push_ent.status = st;

   always_ff @(posedge clock) begin
      if (reset || (accept && in_last)) begin
         pos_ff   <= 16'd0;
         nlp_ff   <= LABEL_POS_RESET;
         root_ff  <= 16'd0;
         qch_ff   <= 8'd0;
         err_ff   <= ST_OK;
         phase_ff <= PH_HEADER;
      end else if (accept) begin
         pos_ff   <= pos_in;
         nlp_ff   <= nlp_in;
         root_ff  <= root_in;
         qch_ff   <= qch_in;
         err_ff   <= err_in;
         phase_ff <= phase_in;
      end
   end

endmodule

// File: sv/dnsrw_queue.sv
// Short queue between the parser and the reply generator.
module dnsrw_queue
   import dnsrw_pkg::*;
#(
   parameter int Depth = 4
)
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   output logic     push_ready,
   input  qent_type push_ent,
   output logic     pop_valid,
   input  logic     pop_ready,
   output qent_type pop_ent
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   qent_type            mem_ff [Depth];
   logic [PtrW-1:0]     wr_ff, wr_in;
   logic [PtrW-1:0]     rd_ff, rd_in;
   logic [CntW-1:0]     cnt_ff;
   logic                do_push, do_pop;

   assign push_ready = (cnt_ff != CntW'(Depth));
   assign pop_valid  = (cnt_ff != '0);
   assign pop_ent    = mem_ff[rd_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;
   assign wr_in      = (wr_ff == PtrW'(Depth - 1)) ? '0 : wr_ff + PtrW'(1);
   assign rd_in      = (rd_ff == PtrW'(Depth - 1)) ? '0 : rd_ff + PtrW'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (do_push) wr_ff <= wr_in;
         if (do_pop)  rd_ff <= rd_in;
         if (do_push && !do_pop)      cnt_ff <= cnt_ff + CntW'(1);
         else if (do_pop && !do_push) cnt_ff <= cnt_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ff] <= push_ent;
   end

endmodule

// File: sv/dnsrw_back.sv
// Back end: forwards kept bytes and closes each frame with the answer or a status.
module dnsrw_back
   import dnsrw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic [31:0] reply_addr,
   input  logic        q_valid,
   output logic        q_ready,
   input  qent_type    q_ent,
   output logic        out_valid,
   input  logic        out_ready,
   output logic [7:0]  out_byte,
   output logic        out_last,
   output logic [2:0]  out_status
);

   logic       byte_done_ff, byte_done_in;
   logic [3:0] tidx_ff, tidx_in;
   logic       valid_ff;
   logic [7:0] byte_ff;
   logic       last_ff;
   logic [2:0] status_ff;

   logic       load_en;
   logic       fire;
   logic [7:0] c_byte;
   logic       c_last;
   logic [2:0] c_status;

   assign load_en = !valid_ff || out_ready;
   assign fire    = q_valid && load_en;

   always_comb begin
      c_byte       = q_ent.data;
      c_last       = 1'b0;
      c_status     = ST_OK;
      q_ready      = 1'b0;
      byte_done_in = byte_done_ff;
      tidx_in      = tidx_ff;
      if (q_ent.keep && !byte_done_ff) begin
         // forwarded query byte; an end-of-frame entry stays for its closing part
         if (q_ent.last) byte_done_in = 1'b1;
         else            q_ready      = load_en;
      end else if (q_ent.status == ST_OK) begin
         c_byte  = tail_byte(tidx_ff, reply_addr);
         c_last  = (tidx_ff == TAIL_LAST_IDX);
         tidx_in = tidx_ff + 4'd1;
         if (tidx_ff == TAIL_LAST_IDX) begin
            q_ready      = load_en;
            byte_done_in = 1'b0;
         end
      end else begin
         c_byte       = 8'h00;
         c_last       = 1'b1;
         c_status     = q_ent.status;
         q_ready      = load_en;
         byte_done_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_done_ff <= 1'b0;
         tidx_ff      <= 4'd0;
         valid_ff     <= 1'b0;
      end else begin
         if (fire) begin
            byte_done_ff <= byte_done_in;
            tidx_ff      <= tidx_in;
         end
         if (load_en) valid_ff <= q_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         byte_ff   <= c_byte;
         last_ff   <= c_last;
         status_ff <= c_status;
      end
   end

   assign out_valid  = valid_ff;
   assign out_byte   = byte_ff;
   assign out_last   = last_ff;
   assign out_status = status_ff;

endmodule

// File: sv/dns_query_to_a_reply_rewriter_top.sv
// A kept request byte passes through the queue and then the back end's output register to the results.
// Throughput: one request per cycle within a frame while the queue has room. A good frame's final
// entry holds the back end for its byte, if kept, and the 16-byte answer; a bad frame's for its
// byte, if kept, and a closing status. The front keeps taking bytes only until the QueueDepth-entry
// queue fills, then req_tready drops.
// Reset is synchronous; it clears parse state, queue, output register and sets the
// capacity register to 512 and the address register to zero. No clearing pass.
module dns_query_to_a_reply_rewriter_top
   import dnsrw_pkg::*;
#(
   parameter int QueueDepth = 4
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_byte
   output logic        rsp_tlast,
   output logic [2:0]  rsp_tuser,   // [2:0] status
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [31:0] csr_data
);

   logic [31:0] reply_addr_ff;
   logic [15:0] buf_cap_ff;

   logic     push_valid, push_ready;
   qent_type push_ent;
   logic     pop_valid, pop_ready;
   qent_type pop_ent;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         reply_addr_ff <= 32'd0;
         buf_cap_ff    <= BUF_CAP_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_REPLY_ADDR: reply_addr_ff <= csr_data;
            CSR_BUF_CAP:    buf_cap_ff    <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   dnsrw_front u_front (
      .clock      (clock),
      .reset      (reset),
      .buf_cap    (buf_cap_ff),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_byte    (req_tdata),
      .in_last    (req_tlast),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_ent   (push_ent)
   );

   dnsrw_queue #(.Depth(QueueDepth)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_ent   (push_ent),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_ent    (pop_ent)
   );

   dnsrw_back u_back (
      .clock      (clock),
      .reset      (reset),
      .reply_addr (reply_addr_ff),
      .q_valid    (pop_valid),
      .q_ready    (pop_ready),
      .q_ent      (pop_ent),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_byte   (rsp_tdata),
      .out_last   (rsp_tlast),
      .out_status (rsp_tuser)
   );

endmodule

// File: sv/dnsrw_checker.sv
// Port-level checks for the rewriter, bound to the top level.
module dnsrw_checker
   import dnsrw_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast,
   input logic [2:0] rsp_tuser
);

   // a status only ever rides on the closing result
   a_status_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != ST_OK |-> rsp_tlast)
      else $error("nonzero status on a non-final result");

   // a rejected frame closes with a zero byte
   a_bad_end_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast && rsp_tuser != ST_OK |-> rsp_tdata == 8'd0)
      else $error("rejected frame end carries data");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
      $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("stalled result changed");

endmodule

bind dns_query_to_a_reply_rewriter_top dnsrw_checker u_dnsrw_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);
